// ----- rtl/two_pole_bandpass_resonator_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-pole band-pass resonator core
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TWO_POLE_BANDPASS_RESONATOR_CORE_MACROS_SVH
`define TWO_POLE_BANDPASS_RESONATOR_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define TPBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define TPBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tpbr_pkg.sv -----
// ----------------------------------------------------------------------------
// tpbr_pkg
// Types and constants shared by the resonator core: configuration register
// indexes, coefficient widths and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tpbr_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Coefficient widths (Q2.30 style words)
  localparam int GAIN_W = 31;
  localparam int FB1_W  = 32;
  localparam int FB2_W  = 31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_COEF   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FB    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_FB   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MODE = 8'd3;

  // Configuration bundle handed from the register file to the datapath
  typedef struct packed {
    logic [GAIN_W-1:0]        gain_coef;
    logic signed [FB1_W-1:0]  first_feedback_coef;
    logic [FB2_W-1:0]         second_feedback_coef;
    logic                     invert_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/two_pole_bandpass_resonator_core.sv -----
// Path: input register, then result register driving out_tvalid.
// Throughput: 1 sample per cycle while out_tready keeps the result
//   register free; the y[n-1] feedback multiply, sum, round and saturate
//   close combinationally between the two registers.
// Reset: synchronous active-low rst_n clears coefficients, invert flag,
//   sample history and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// two_pole_bandpass_resonator_core
// Top level: streaming input and result channels, configuration port, and
// the input/result register pair around the resonator datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_pole_bandpass_resonator_core_macros.svh"

module two_pole_bandpass_resonator_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 30
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // tdata: [SAMPLE_BITS-1:0] sample_in, zero padded to bytes
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: [SAMPLE_BITS-1:0] sample_out, zero padded to bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  // tuser: [0] clipped
  output logic [0:0]                          out_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tpbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpbr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  tpbr_pkg::cfg_t cfg;

  logic                 s1_v_r, s1_v_nxt;
  logic signed [SB-1:0] s1_x_r;
  logic                 out_v_r, out_v_nxt;
  logic signed [SB-1:0] out_sample_r;
  logic                 out_clip_r;
  logic                 advance;
  logic                 in_acc;
  logic signed [SB-1:0] dp_sample;
  logic                 dp_clip;
  logic                 dp_filt_clip;

  // Configuration registers
  tpbr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Resonator arithmetic and history
  tpbr_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .x         (s1_x_r),
    .cfg       (cfg),
    .res       (dp_sample),
    .clip      (dp_clip),
    .filt_clip (dp_filt_clip)
  );

  // Handshake: the held sample moves on when the result register frees up
  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r <= signed'(in_tdata[SB-1:0]);
    end
    if (advance) begin
      out_sample_r <= dp_sample;
      out_clip_r   <= dp_clip;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = DATA_W'(unsigned'(out_sample_r));
  assign out_tuser  = out_clip_r;

  // Assertions
  `TPBR_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, advance, out_tvalid,
                    "advanced sample did not reach the result register")
  `TPBR_ASSERT_NEXT(a_stall_holds_s1, clk, rst_n,
                    s1_v_r && out_tvalid && !out_tready, s1_v_r,
                    "held sample lost while the result stalled")
  `TPBR_ASSERT_SAME(a_clip_at_rail, clk, rst_n,
                    s1_v_r && !cfg.invert_mode && dp_filt_clip,
                    dp_sample == SMAX || dp_sample == SMIN,
                    "saturated filter result is not at a rail")

endmodule

`default_nettype wire

// ----- rtl/tpbr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tpbr_cfg_regs
// Configuration register file: takes one write transaction per cycle and
// holds the three coefficients and the invert flag. Unknown indexes are
// ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tpbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpbr_pkg::CFG_DATA_W-1:0] cfg_data,
  output tpbr_pkg::cfg_t                      cfg
);

  tpbr_pkg::cfg_t cfg_r, cfg_nxt;

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Next value: decode the index of a completed write transaction
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tpbr_pkg::REG_GAIN_COEF: begin
          cfg_nxt.gain_coef = cfg_data[tpbr_pkg::GAIN_W-1:0];
        end
        tpbr_pkg::REG_FIRST_FB: begin
          cfg_nxt.first_feedback_coef = signed'(cfg_data[tpbr_pkg::FB1_W-1:0]);
        end
        tpbr_pkg::REG_SECOND_FB: begin
          cfg_nxt.second_feedback_coef = cfg_data[tpbr_pkg::FB2_W-1:0];
        end
        tpbr_pkg::REG_INVERT_MODE: begin
          cfg_nxt.invert_mode = cfg_data[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/tpbr_datapath.sv -----
// ----------------------------------------------------------------------------
// tpbr_datapath
// Resonator arithmetic and sample history. Three products are summed
// exactly, rounded half up, saturated, and optionally subtracted from the
// input. The history shifts on every sample that advances.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbr_datapath #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 30
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire tpbr_pkg::cfg_t                cfg,
  output logic signed [SAMPLE_BITS-1:0]      res,
  output logic                               clip,
  output logic                               filt_clip
);

  localparam int SB    = SAMPLE_BITS;
  localparam int ACC_W = SB + 35;

  localparam logic signed [SB-1:0]    SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]    SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  // History: two past inputs and two past saturated filter outputs
  logic signed [SB-1:0] xd1_r, xd2_r, yd1_r, yd2_r;

  logic signed [SB:0]         xdiff;
  logic signed [31:0]         gain_s;
  logic signed [31:0]         fb2_s;
  logic signed [32+SB:0]      p0;
  logic signed [32+SB-1:0]    p1;
  logic signed [32+SB-1:0]    p2;
  logic signed [ACC_W-1:0]    sum;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SB-1:0]       filt;
  logic signed [SB:0]         idiff;
  logic                       inv_clip;

  // Products: a1*(x - x[n-2]), b1*y[n-1], b2*y[n-2]
  always_comb begin
    xdiff  = {x[SB-1], x} - {xd2_r[SB-1], xd2_r};
    gain_s = signed'({1'b0, cfg.gain_coef});
    fb2_s  = signed'({1'b0, cfg.second_feedback_coef});
    p0     = gain_s * xdiff;
    p1     = cfg.first_feedback_coef * yd1_r;
    p2     = fb2_s * yd2_r;
  end

  // Exact sum, round half up, drop the fraction
  always_comb begin
    sum = ACC_W'(p0) - ACC_W'(p1) - ACC_W'(p2);
    acc = (sum + HALF) >>> COEF_FRAC_BITS;
  end

  // Saturate the filtered value to the sample range
  always_comb begin
    filt_clip = 1'b0;
    if (acc > ACC_W'(SMAX)) begin
      filt      = SMAX;
      filt_clip = 1'b1;
    end else if (acc < ACC_W'(SMIN)) begin
      filt      = SMIN;
      filt_clip = 1'b1;
    end else begin
      filt = acc[SB-1:0];
    end
  end

  // Band-stop style: input minus filtered value, saturated again
  always_comb begin
    idiff    = {x[SB-1], x} - {filt[SB-1], filt};
    inv_clip = 1'b0;
    if (cfg.invert_mode) begin
      if (idiff[SB] != idiff[SB-1]) begin
        res      = idiff[SB] ? SMIN : SMAX;
        inv_clip = 1'b1;
      end else begin
        res = idiff[SB-1:0];
      end
    end else begin
      res = filt;
    end
    clip = filt_clip | inv_clip;
  end

  // History shift on each advancing sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xd1_r <= '0;
      xd2_r <= '0;
      yd1_r <= '0;
      yd2_r <= '0;
    end else if (advance) begin
      xd2_r <= xd1_r;
      xd1_r <= x;
      yd2_r <= yd1_r;
      yd1_r <= filt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/two_pole_bandpass_resonator_core_test.sv -----
// ----------------------------------------------------------------------------
// two_pole_bandpass_resonator_core_test
// Self-checking bench for the resonator core. A clocked driver streams Q1.23
// samples from a queue, and a clocked monitor compares each filtered sample
// and its clip flag with a bit-exact predictor of the two-pole recursion. The
// coefficients and invert flag are reprogrammed between phases while the core
// is idle. Both sides idle in random bursts, and one long receiver hold-off
// backs the core up.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pole_bandpass_resonator_core_test;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_FRAC  = 30;
  localparam int DATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_ITEMS      = 225;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [31:0] COEF_ONE = 32'h4000_0000;  // 1.0 in Q2.30

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
  } filtered_sample_t;

  // DUT ports
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [tpbr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tpbr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor state: coefficients and sample history
  longint gain_q30, fb1_q30, fb2_q30;
  bit     invert_on;
  longint hist_x1, hist_x2, hist_y1, hist_y2;

  logic [SAMPLE_W-1:0] pending_samples[$];
  filtered_sample_t    expected_results[$];

  bit sender_idle_en   = 1'b1;
  bit receiver_idle_en = 1'b1;
  int in_gap           = 0;
  int out_gap          = 0;
  int hold_left        = 0;
  bit hold_armed       = 1'b0;
  int mismatch_count   = 0;
  int cycle_count      = 0;

  two_pole_bandpass_resonator_core #(
    .SAMPLE_BITS    (SAMPLE_W),
    .COEF_FRAC_BITS (COEF_FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamp to the signed sample range
  function automatic longint clamp_sample(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // y = a1*(x - x[n-2]) - b1*y[n-1] - b2*y[n-2], rounded half up, saturated;
  // the saturated value feeds back, invert mode gives x - y saturated again
  function automatic void predict_filtered(input logic [SAMPLE_W-1:0] raw);
    longint x, acc, filt, diff;
    filtered_sample_t item;
    x    = longint'($signed(raw));
    acc  = gain_q30 * (x - hist_x2) - fb1_q30 * hist_y1 - fb2_q30 * hist_y2;
    acc  = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    filt = clamp_sample(acc);
    item.clipped = (filt != acc);
    hist_x2 = hist_x1;
    hist_x1 = x;
    hist_y2 = hist_y1;
    hist_y1 = filt;
    if (invert_on) begin
      diff = x - filt;
      filt = clamp_sample(diff);
      if (filt != diff) item.clipped = 1'b1;
    end
    item.sample = filt[SAMPLE_W-1:0];
    expected_results.push_back(item);
  endfunction

  // Mostly full-scale random, with extremes and small values mixed in
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Sender: one transaction per handshake, random idle bursts between items
  always @(posedge clk) begin : sender
    bit next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_filtered(in_tdata[SAMPLE_W-1:0]);
      if (!in_tvalid || in_tready) begin
        next_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_samples.size() != 0) begin
          if (sender_idle_en && $urandom_range(0, 11) == 0) begin
            in_gap = $urandom_range(0, 17);
          end else begin
            next_valid = 1'b1;
            in_tdata <= DATA_W'(pending_samples.pop_front());
          end
        end
        in_tvalid <= next_valid;
      end
    end
  end

  // Long receiver hold-off, counted here so the monitor sees a clean flag
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed) begin
      hold_left  <= LONG_HOLD_CYCLES;
      hold_armed <= 1'b0;
    end
  end

  // Receiver: check each result transaction against the oldest expectation
  always @(posedge clk) begin : receiver
    bit next_ready;
    filtered_sample_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0d] unexpected result: sample %0d clipped %0b", cycle_count,
                     $signed(out_tdata[SAMPLE_W-1:0]), out_tuser[0]);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want.sample || out_tuser[0] !== want.clipped) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0d] mismatch: sample exp %0d got %0d, clipped exp %0b got %0b",
                       cycle_count, $signed(want.sample), $signed(out_tdata[SAMPLE_W-1:0]),
                       want.clipped, out_tuser[0]);
          end
        end
      end
      next_ready = 1'b1;
      if (hold_left != 0) begin
        next_ready = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        next_ready = 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(0, 17);
        next_ready = 1'b0;
      end
      out_tready <= next_ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Register write; the predictor takes the value once the core accepts it
  task automatic write_reg(input logic [tpbr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tpbr_pkg::REG_GAIN_COEF:   gain_q30  = longint'(val[tpbr_pkg::GAIN_W-1:0]);
      tpbr_pkg::REG_FIRST_FB:    fb1_q30   = longint'($signed(val));
      tpbr_pkg::REG_SECOND_FB:   fb2_q30   = longint'(val[tpbr_pkg::FB2_W-1:0]);
      tpbr_pkg::REG_INVERT_MODE: invert_on = val[0];
      default: ;  // unmapped index, no effect
    endcase
    @(posedge clk);
  endtask

  // Wait until every sample has been taken and every result returned;
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_setting(input logic [31:0] g, input logic [31:0] f1,
                                 input logic [31:0] f2, input bit inv);
    write_reg(tpbr_pkg::REG_GAIN_COEF, g);
    write_reg(tpbr_pkg::REG_FIRST_FB, f1);
    write_reg(tpbr_pkg::REG_SECOND_FB, f2);
    write_reg(tpbr_pkg::REG_INVERT_MODE, {31'($urandom), inv});
  endtask

  // Phase settings: stable resonators, raw bit patterns and extremes
  task automatic program_random_setting(input int kind);
    longint lim, f1;
    logic [31:0] g, f2;
    case (kind)
      1: begin
        program_setting($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
      2: begin
        case ($urandom_range(0, 2))
          0: g = '0;
          1: g = COEF_ONE;
          default: g = 32'h7FFF_FFFF;
        endcase
        case ($urandom_range(0, 2))
          0: f2 = '0;
          1: f2 = COEF_ONE;
          default: f2 = 32'h7FFF_FFFF;
        endcase
        case ($urandom_range(0, 2))
          0: f1 = 0;
          1: f1 = 32'h7FFF_FFFF;
          default: f1 = -(longint'(1) <<< 31);
        endcase
        program_setting(g, 32'(f1), f2, 1'($urandom_range(0, 1)));
      end
      default: begin
        // poles inside or on the unit circle: r^2 in [0.75, 1.0], |b1| < 1 + r^2
        f2  = $urandom_range(32'h3000_0000, COEF_ONE);
        lim = longint'(COEF_ONE) + longint'(f2) - 1;
        f1  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        g   = $urandom_range(0, 32'h0400_0000);
        program_setting(g, 32'(f1), f2, kind == 3);
      end
    endcase
    // writes to unmapped indexes must leave the setting alone
    write_reg(tpbr_pkg::REG_INVERT_MODE +
              tpbr_pkg::CFG_IDX_W'($urandom_range(1, 252)), $urandom);
  endtask

  initial begin
    gain_q30  = 0;
    fb1_q30   = 0;
    fb2_q30   = 0;
    invert_on = 1'b0;
    hist_x1   = 0;
    hist_x2   = 0;
    hist_y1   = 0;
    hist_y2   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset setting: all coefficients zero, output stays zero
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back('0);
    pending_samples.push_back('1);
    pending_samples.push_back(SAMPLE_W'(1));
    wait_drained();

    // Narrow resonator, impulses at both extremes
    program_setting(32'd10737418, -32'sd2031053000, 32'd1052353479, 1'b0);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(SAMPLE_W'(1));
    pending_samples.push_back('1);
    wait_drained();

    // Unity gain, no feedback: x - x[n-2] runs into both rails
    program_setting(COEF_ONE, '0, '0, 1'b0);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back(SAMPLE_MAX);
    wait_drained();

    // Gain near 2.0 from an all-ones write, invert on: x - y saturates too
    program_setting(32'hFFFF_FFFF, '0, '0, 1'b1);
    pending_samples.push_back(SAMPLE_MAX);
    pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_W'(1000000));
    pending_samples.push_back(SAMPLE_MIN);
    pending_samples.push_back('1);
    wait_drained();

    // Random phases; the third one backs the core up, the last one runs flat out
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_random_setting(phase % 4);
      sender_idle_en   = (phase != 2) && (phase != RANDOM_PHASES - 1);
      receiver_idle_en = (phase != RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_samples.push_back(random_sample());
      if (phase == 2) hold_armed <= 1'b1;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
